FILE: hdl/n2a_pkg.sv
// shared constants, types and helpers for the number to ascii formatter
// no dependencies; used by n2a_dabble, n2a_emit and number_to_ascii_digits
`timescale 1ns / 1ps

package n2a_pkg;

  // width of the value that is formatted, and of the value port
  localparam int VALUE_W = 32;
  localparam int IN_W    = 32;

  // decimal digits for the full range, at least four for the fixed format
  localparam int DEC_DIG = (VALUE_W * 30103) / 100000 + 1;
  localparam int BCD_DIG = (DEC_DIG > 4) ? DEC_DIG : 4;
  localparam int BCD_W   = BCD_DIG * 4;

  // value padded to whole hex digits
  localparam int HEX_W   = ((VALUE_W + 3) / 4) * 4;

  // digit shift register feeding the character output
  localparam int BUF_W   = (HEX_W > BCD_W) ? HEX_W : BCD_W;
  localparam int CNT_W   = $clog2(VALUE_W + 1);

  // four-digit decimal format
  localparam int FIX_DIG = 4;
  localparam int FIX_W   = FIX_DIG * 4;

  localparam logic [6:0] ASCII_ZERO  = 7'h30;
  localparam logic [6:0] ASCII_A     = 7'h41;
  localparam logic [6:0] ASCII_MINUS = 7'h2D;
  localparam logic [3:0] DIGIT_TEN   = 4'd10;

  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_BIN  = 2'd1,
    OP_HEX  = 2'd2,
    OP_DEC4 = 2'd3
  } n2a_op_e;

  // one formatting job handed to the character emitter
  typedef struct packed {
    logic [BUF_W-1:0] digits;
    logic [CNT_W-1:0] count;
    logic             step1;
    logic             skip;
    logic             sign;
  } n2a_load_t;

  // digit value to its ascii character, uppercase for hex
  function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
    logic [6:0] c;
    if (d < DIGIT_TEN) begin
      c = ASCII_ZERO + {3'b000, d};
    end else begin
      c = ASCII_A + {3'b000, d - DIGIT_TEN};
    end
    return c;
  endfunction

endpackage

FILE: hdl/number_to_ascii_digits.sv
// number to ascii formatter: decimal through a bit-serial double dabble,
// binary and hex straight from the value; signed decimal, binary and hex drop
// leading zeros (after the minus sign, if any), four-digit decimal keeps them;
// a new value is taken only once the previous one is converted and emitted;
// async active-low reset idles all control
`timescale 1ns / 1ps

module number_to_ascii_digits (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               operation_i,
  input  logic [n2a_pkg::IN_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [6:0]               ascii_char_o,
  output logic                     last_o
);

  localparam int VW   = n2a_pkg::VALUE_W;
  localparam int HW   = n2a_pkg::HEX_W;
  localparam int BCW  = n2a_pkg::BCD_W;
  localparam int BUFW = n2a_pkg::BUF_W;
  localparam int CW   = n2a_pkg::CNT_W;
  localparam int FW   = n2a_pkg::FIX_W;

  typedef enum logic [1:0] {
    TS_IDLE = 2'b01,
    TS_CONV = 2'b10
  } top_state_e;

  top_state_e state_q, state_d;
  logic       dec4_q;
  logic       neg_q;

  n2a_pkg::n2a_op_e   op_in;
  logic [VW-1:0]      v_w;
  logic [VW-1:0]      mag;
  logic               neg_in;
  logic               accept;
  logic               is_dec;
  logic               dab_start;
  logic               dab_done;
  logic [BCW-1:0]     bcd;
  logic               emit_busy;
  logic               emit_load;
  n2a_pkg::n2a_load_t load_data;

  // input decode and magnitude
  always_comb begin
    op_in  = n2a_pkg::n2a_op_e'(operation_i);
    v_w    = VW'(value_i);
    neg_in = (op_in == n2a_pkg::OP_SDEC) && v_w[VW-1];
    mag    = neg_in ? (~v_w + VW'(1)) : v_w;
    is_dec = (op_in == n2a_pkg::OP_SDEC) || (op_in == n2a_pkg::OP_DEC4);
  end

  assign in_stall_o = (state_q != TS_IDLE) || emit_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign dab_start  = accept && is_dec;
  assign emit_load  = (accept && !is_dec) || ((state_q == TS_CONV) && dab_done);

  // job for the emitter
  always_comb begin
    load_data = '0;
    if (state_q == TS_CONV) begin
      if (dec4_q) begin
        load_data.digits = BUFW'(bcd[FW-1:0]) << (BUFW - FW);
        load_data.count  = CW'(n2a_pkg::FIX_DIG);
        load_data.skip   = 1'b0;
      end else begin
        load_data.digits = BUFW'(bcd) << (BUFW - BCW);
        load_data.count  = CW'(n2a_pkg::BCD_DIG);
        load_data.skip   = 1'b1;
        load_data.sign   = neg_q;
      end
    end else begin
      case (op_in)
        n2a_pkg::OP_BIN: begin
          load_data.digits = BUFW'(v_w) << (BUFW - VW);
          load_data.count  = CW'(VW);
          load_data.step1  = 1'b1;
          load_data.skip   = 1'b1;
        end
        default: begin
          load_data.digits = BUFW'(HW'(v_w)) << (BUFW - HW);
          load_data.count  = CW'(HW / 4);
          load_data.skip   = 1'b1;
        end
      endcase
    end
  end

  // conversion sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      TS_IDLE: begin
        if (dab_start) begin
          state_d = TS_CONV;
        end
      end
      TS_CONV: begin
        if (dab_done) begin
          state_d = TS_IDLE;
        end
      end
      default: begin
        state_d = TS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // format of the decimal job in flight
  always_ff @(posedge clk_i) begin
    if (dab_start) begin
      dec4_q <= (op_in == n2a_pkg::OP_DEC4);
      neg_q  <= neg_in;
    end
  end

  n2a_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dab_start),
    .value_i (mag),
    .done_o  (dab_done),
    .bcd_o   (bcd)
  );

  n2a_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (emit_load),
    .load_data_i  (load_data),
    .busy_o       (emit_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ascii_char_o (ascii_char_o),
    .last_o       (last_o)
  );

endmodule

FILE: hdl/n2a_dabble.sv
// bit-serial double-dabble binary to bcd converter, one value bit per cycle
// depends on n2a_pkg
`timescale 1ns / 1ps

module n2a_dabble (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [n2a_pkg::VALUE_W-1:0] value_i,
  output logic                        done_o,
  output logic [n2a_pkg::BCD_W-1:0]   bcd_o
);

  localparam int VW    = n2a_pkg::VALUE_W;
  localparam int NDIG  = n2a_pkg::BCD_DIG;
  localparam int BW    = n2a_pkg::BCD_W;
  localparam int CW    = n2a_pkg::CNT_W;

  logic [VW-1:0] bin_q;
  logic [BW-1:0] bcd_q;
  logic [BW-1:0] corr;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic          running;

  assign running = (cnt_q != '0);

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        corr[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        corr[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // bit counter and completion flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= running && (cnt_q == CW'(1));
      if (start_i) begin
        cnt_q <= CW'(VW);
      end else if (running) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // shift the value msb first into the bcd register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (running) begin
      bcd_q <= {corr[BW-2:0], bin_q[VW-1]};
      bin_q <= {bin_q[VW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

FILE: hdl/n2a_emit.sv
// character emitter: shifts digits out msb first, drops leading zeros on request,
// adds the minus sign and holds each character in an output register; uses n2a_pkg
`timescale 1ns / 1ps

module n2a_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  n2a_pkg::n2a_load_t load_data_i,
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [6:0]         ascii_char_o,
  output logic               last_o
);

  localparam int BW = n2a_pkg::BUF_W;
  localparam int CW = n2a_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SIGN = 3'b010,
    ST_RUN  = 3'b100
  } emit_state_e;

  emit_state_e state_q, state_d;
  logic [BW-1:0] buf_q;
  logic [CW-1:0] cnt_q;
  logic          step1_q;
  logic          skip_q;
  logic          lead_q;
  logic          out_valid_q;
  logic [6:0]    char_q;
  logic          last_q;

  logic [3:0]    digit;
  logic          is_last;
  logic          out_free;
  logic          drop;
  logic          emit_dig;
  logic          emit_sign;
  logic          shift;
  logic [BW-1:0] buf_shifted;

  // current digit and step decisions
  always_comb begin
    digit       = step1_q ? {3'b000, buf_q[BW-1]} : buf_q[BW-1 -: 4];
    is_last     = (cnt_q == CW'(1));
    out_free    = !out_valid_q || !out_stall_i;
    drop        = (state_q == ST_RUN) && skip_q && lead_q && (digit == 4'd0) && !is_last;
    emit_dig    = (state_q == ST_RUN) && !drop && out_free;
    emit_sign   = (state_q == ST_SIGN) && out_free;
    shift       = drop || emit_dig;
    buf_shifted = step1_q ? {buf_q[BW-2:0], 1'b0} : {buf_q[BW-5:0], 4'b0000};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (load_i) begin
          state_d = load_data_i.sign ? ST_SIGN : ST_RUN;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (emit_dig && is_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      lead_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_i) begin
        cnt_q  <= load_data_i.count;
        lead_q <= 1'b1;
      end else if (shift) begin
        cnt_q <= cnt_q - CW'(1);
        if (emit_dig) begin
          lead_q <= 1'b0;
        end
      end
      if (emit_dig || emit_sign) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // digit shift register and output beat
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q   <= load_data_i.digits;
      step1_q <= load_data_i.step1;
      skip_q  <= load_data_i.skip;
    end else if (shift) begin
      buf_q <= buf_shifted;
    end
    if (emit_sign) begin
      char_q <= n2a_pkg::ASCII_MINUS;
      last_q <= 1'b0;
    end else if (emit_dig) begin
      char_q <= n2a_pkg::digit_to_ascii(digit);
      last_q <= is_last;
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = char_q;
  assign last_o       = last_q;

`ifndef SYNTH
  a_run_has_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q != '0))
    else $error("emitter running with no digits left");

  a_load_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (state_q == ST_IDLE))
    else $error("job loaded while emitter busy");

  a_last_ends_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_dig && is_last) |=> (state_q == ST_IDLE && out_valid_q && last_q))
    else $error("final digit did not end the job");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_sign |=> (out_valid_q && !last_q && char_q == n2a_pkg::ASCII_MINUS))
    else $error("minus sign beat malformed");
`endif

endmodule

FILE: test/number_to_ascii_digits_tb.sv
// testbench for number_to_ascii_digits: directed table then random values in three idle phases
// depends on n2a_pkg and the number_to_ascii_digits rtl
`timescale 1ns / 1ps

module number_to_ascii_digits_tb;

  localparam int VW               = n2a_pkg::VALUE_W;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_CYCLES     = 2 * VW + 16;
  localparam int RANDOM_PER_PHASE = 146;

  // one output character beat
  typedef struct packed {
    logic [6:0] ascii;
    logic       last;
  } char_beat_t;

  // directed row: empty text means the predictor supplies the characters
  typedef struct {
    n2a_pkg::n2a_op_e         op;
    logic [n2a_pkg::IN_W-1:0] value;
    string                    text;
  } directed_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [1:0]               operation_i;
  logic [n2a_pkg::IN_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [6:0]               ascii_char_o;
  logic                     last_o;

  char_beat_t pending_chars[$];
  int         mismatch_count;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_req;

  directed_row_t directed_rows[$] = '{
    '{n2a_pkg::OP_SDEC, 32'h0000_0000, "0"},
    '{n2a_pkg::OP_SDEC, 32'h0000_0001, "1"},
    '{n2a_pkg::OP_SDEC, 32'hFFFF_FFFF, "-1"},
    '{n2a_pkg::OP_SDEC, 32'h7FFF_FFFF, "2147483647"},
    '{n2a_pkg::OP_SDEC, 32'h8000_0000, "-2147483648"},
    '{n2a_pkg::OP_SDEC, 32'h8000_0001, ""},
    '{n2a_pkg::OP_SDEC, 32'd123456789, ""},
    '{n2a_pkg::OP_BIN,  32'h0000_0000, "0"},
    '{n2a_pkg::OP_BIN,  32'h0000_0001, "1"},
    '{n2a_pkg::OP_BIN,  32'h0000_0005, "101"},
    '{n2a_pkg::OP_BIN,  32'hFFFF_FFFF, "11111111111111111111111111111111"},
    '{n2a_pkg::OP_BIN,  32'h8000_0000, ""},
    '{n2a_pkg::OP_HEX,  32'h0000_0000, "0"},
    '{n2a_pkg::OP_HEX,  32'h0000_000A, "A"},
    '{n2a_pkg::OP_HEX,  32'hFFFF_FFFF, "FFFFFFFF"},
    '{n2a_pkg::OP_HEX,  32'hDEAD_BEEF, "DEADBEEF"},
    '{n2a_pkg::OP_HEX,  32'h1234_5678, ""},
    '{n2a_pkg::OP_DEC4, 32'd0,         "0000"},
    '{n2a_pkg::OP_DEC4, 32'd42,        "0042"},
    '{n2a_pkg::OP_DEC4, 32'd9999,      "9999"},
    '{n2a_pkg::OP_DEC4, 32'd10000,     "0000"},
    '{n2a_pkg::OP_DEC4, 32'hFFFF_FFFF, "7295"},
    '{n2a_pkg::OP_DEC4, 32'd12345,     ""}
  };

  number_to_ascii_digits DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ascii_char_o (ascii_char_o),
    .last_o       (last_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // characters of one value, most significant first, queued as expected beats
  function automatic void predict_chars(input n2a_pkg::n2a_op_e op,
                                        input logic [n2a_pkg::IN_W-1:0] raw);
    logic [VW-1:0] mag;
    logic [3:0]    nib;
    logic [6:0]    digits[$];
    char_beat_t    beat;
    bit            negative;
    mag      = VW'(raw);
    negative = 1'b0;
    case (op)
      n2a_pkg::OP_SDEC: begin
        if (mag[VW-1]) begin
          negative = 1'b1;
          mag      = -mag;
        end
        do begin
          digits.push_front(n2a_pkg::ASCII_ZERO + 7'(mag % 10));
          mag = mag / 10;
        end while (mag != 0);
      end
      n2a_pkg::OP_BIN: begin
        do begin
          digits.push_front(n2a_pkg::ASCII_ZERO + {6'd0, mag[0]});
          mag = mag >> 1;
        end while (mag != 0);
      end
      n2a_pkg::OP_HEX: begin
        do begin
          nib = mag[3:0];
          digits.push_front((nib < 4'd10) ? n2a_pkg::ASCII_ZERO + {3'd0, nib}
                                          : n2a_pkg::ASCII_A + {3'd0, nib - 4'd10});
          mag = mag >> 4;
        end while (mag != 0);
      end
      default: begin
        mag = mag % 10000;
        repeat (n2a_pkg::FIX_DIG) begin
          digits.push_front(n2a_pkg::ASCII_ZERO + 7'(mag % 10));
          mag = mag / 10;
        end
      end
    endcase
    if (negative) begin
      digits.push_front(n2a_pkg::ASCII_MINUS);
    end
    foreach (digits[i]) begin
      beat.ascii = digits[i];
      beat.last  = (i == digits.size() - 1);
      pending_chars.push_back(beat);
    end
  endfunction

  // random value shaped toward edges, small numbers and short widths
  function automatic logic [n2a_pkg::IN_W-1:0] pick_value();
    logic [n2a_pkg::IN_W-1:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(20);
      2: v = $urandom >> $urandom_range(31);
      3: v = (32'h1 << $urandom_range(31)) + $urandom_range(2) - 1;
      4: begin
        case ($urandom_range(5))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h8000_0000;
          3: v = 32'h7FFF_FFFF;
          4: v = 32'd9999;
          default: v = 32'd10000;
        endcase
      end
      default: v = -($urandom >> $urandom_range(31));
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // offer one beat after optional idle cycles, return once accepted
  task automatic drive_value(input n2a_pkg::n2a_op_e op,
                             input logic [n2a_pkg::IN_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i  <= 1'b0;
      operation_i <= 2'($urandom);
      value_i     <= $urandom;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // drop valid and hold off until every expected character has come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk_i);
  endtask

  // receiver: random stall, or a long hold-off when requested
  initial begin
    int hold_count;
    int hold_taken;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_taken != hold_req) begin
        out_stall_i <= 1'b1;
        hold_count++;
        if (hold_count == HOLD_CYCLES) begin
          hold_count = 0;
          hold_taken = hold_req;
        end
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // output checker
  always @(posedge clk_i) begin
    char_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected beat, char", ascii_char_o, 0);
      end else begin
        want = pending_chars.pop_front();
        if (ascii_char_o !== want.ascii) begin
          report_mismatch("ascii_char", ascii_char_o, want.ascii);
        end
        if (last_o !== want.last) begin
          report_mismatch("last", last_o, want.last);
        end
      end
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // stimulus
  initial begin
    n2a_pkg::n2a_op_e op;
    char_beat_t       beat;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = 2'd0;
    value_i        = '0;
    mismatch_count = 0;
    hold_req       = 0;
    send_idle_pct  = 25;
    recv_stall_pct = 59;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    foreach (directed_rows[r]) begin
      drive_value(directed_rows[r].op, directed_rows[r].value);
      if (directed_rows[r].text.len() == 0) begin
        predict_chars(directed_rows[r].op, directed_rows[r].value);
      end else begin
        for (int i = 0; i < directed_rows[r].text.len(); i++) begin
          beat.ascii = 7'(directed_rows[r].text[i]);
          beat.last  = (i == directed_rows[r].text.len() - 1);
          pending_chars.push_back(beat);
        end
      end
    end

    // random values: sender-light, receiver-light, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 25 : (phase == 1) ? 59 : 0;
      recv_stall_pct = (phase == 0) ? 59 : (phase == 1) ? 25 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // long receiver hold-off while values keep coming
        if (phase == 0 && n == 30) begin
          hold_req++;
        end
        // sender pause until the block has emptied
        if (phase == 1 && n == 70) begin
          wait_drained();
        end
        op = n2a_pkg::n2a_op_e'($urandom_range(3));
        drive_value(op, pick_value());
        predict_chars(op, value_i);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
